// ----- hw/rtl/lrm_pkg.sv -----
// Shared types and constants for the layer residency manager.
package lrm_pkg;

   localparam int DEF_MAX_LAYERS = 64;

   localparam int FUNC_W     = 2;
   localparam int IDX_IN_W   = 6;
   localparam int SIZE_W     = 48;
   localparam int CNT_W      = 7;
   localparam int BYTES_W    = 54;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 80;
   localparam int RSP_PAD_W  = RSP_DATA_W - (1 + 3 * CNT_W + BYTES_W);

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic [BYTES_W-1:0] BYTES_MAX   = {BYTES_W{1'b1}};
   localparam logic [CNT_W-1:0]   LC_RESET    = 7'd32;
   localparam logic [CNT_W-1:0]   LIMIT_RESET = 7'd4;

   localparam logic REG_LAYER_COUNT    = 1'b0;
   localparam logic REG_RESIDENT_LIMIT = 1'b1;

   typedef enum logic [FUNC_W-1:0] {
      FN_REGISTER = 2'd0,
      FN_LOAD     = 2'd1,
      FN_UNLOAD   = 2'd2,
      FN_ADVANCE  = 2'd3
   } func_type;

   // broadcast to every cell: rotate the ring, or write one entry at rest
   typedef struct packed {
      logic              shift;
      logic              wr_en;
      logic              size_en;
      logic [CNT_W-1:0]  addr;
      logic              mark;
      logic [SIZE_W-1:0] size;
   } cell_ctl_type;

   typedef struct packed {
      logic             clear;
      logic             step;
      logic [CNT_W-1:0] n;
      logic [CNT_W-1:0] pos;
      logic [CNT_W-1:0] tgt;
   } tally_ctl_type;

   typedef struct packed {
      logic [CNT_W-1:0]   cnt;
      logic [BYTES_W-1:0] bytes;
      logic [CNT_W-1:0]   victim;
      logic               tgt_mark;
      logic [SIZE_W-1:0]  tgt_size;
   } tally_res_type;

endpackage

// ----- hw/rtl/lrm_cell.sv -----
// One table entry of the rotating ring: layer size and resident mark.
module lrm_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lrm_pkg::cell_ctl_type        ctl,
   input  logic [lrm_pkg::SIZE_W-1:0]   next_size,
   input  logic                         next_mark,
   output logic [lrm_pkg::SIZE_W-1:0]   size_q,
   output logic                         mark_q
);
   import lrm_pkg::*;

   logic [SIZE_W-1:0] size_ff, size_in;
   logic              mark_ff, mark_in;
   logic              hit;

   assign hit = ctl.wr_en && (int'(ctl.addr) == CELL_IDX);

   always_comb begin
      size_in = size_ff;
      mark_in = mark_ff;
      if (ctl.shift) begin
         size_in = next_size;
         mark_in = next_mark;
      end else if (hit) begin
         mark_in = ctl.mark;
         if (ctl.size_en) begin
            size_in = ctl.size;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0;
         mark_ff <= 1'b0;
      end else begin
         size_ff <= size_in;
         mark_ff <= mark_in;
      end
   end

   assign size_q = size_ff;
   assign mark_q = mark_ff;

endmodule

// ----- hw/rtl/lrm_tally.sv -----
// Head-of-ring accumulator: resident count, byte sum, victim search, target capture.
module lrm_tally #(
   parameter int MAX_LAYERS = lrm_pkg::DEF_MAX_LAYERS
) (
   input  logic                                             clock,
   input  lrm_pkg::tally_ctl_type                           ctl,
   input  logic [((MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1)-1:0] entry_idx,
   input  logic [lrm_pkg::SIZE_W-1:0]                       entry_size,
   input  logic                                             entry_mark,
   output lrm_pkg::tally_res_type                           res
);
   import lrm_pkg::*;

   localparam int IDX_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int DW    = (IDX_W > CNT_W) ? IDX_W : CNT_W;

   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic               found_ff, found_in;
   logic [DW-1:0]      best_ff, best_in;
   logic [CNT_W-1:0]   victim_ff, victim_in;
   logic               tmark_ff, tmark_in;
   logic [SIZE_W-1:0]  tsize_ff, tsize_in;

   logic               counted;
   logic               is_tgt;
   logic [DW-1:0]      pos_e, idx_e, span;
   logic [BYTES_W:0]   sum;

   assign counted = entry_mark && (int'(entry_idx) < int'(ctl.n));
   assign is_tgt  = int'(entry_idx) == int'(ctl.tgt);
   assign pos_e   = DW'(ctl.pos);
   assign idx_e   = DW'(entry_idx);
   assign span    = (pos_e > idx_e) ? (pos_e - idx_e) : (idx_e - pos_e);
   assign sum     = {1'b0, bytes_ff} + (BYTES_W + 1)'(entry_size);

   always_comb begin
      cnt_in    = cnt_ff;
      bytes_in  = bytes_ff;
      found_in  = found_ff;
      best_in   = best_ff;
      victim_in = victim_ff;
      tmark_in  = tmark_ff;
      tsize_in  = tsize_ff;
      if (ctl.clear) begin
         cnt_in   = '0;
         bytes_in = '0;
         found_in = 1'b0;
         best_in  = '0;
         tmark_in = 1'b0;
         tsize_in = '0;
      end else if (ctl.step) begin
         if (counted) begin
            cnt_in   = cnt_ff + 1'b1;
            bytes_in = (sum > (BYTES_W + 1)'(BYTES_MAX)) ? BYTES_MAX : sum[BYTES_W-1:0];
            // strict compare keeps the lowest index on equal distance
            if (!found_ff || (span > best_ff)) begin
               found_in  = 1'b1;
               best_in   = span;
               victim_in = CNT_W'(entry_idx);
            end
         end
         if (is_tgt) begin
            tmark_in = entry_mark;
            tsize_in = entry_size;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      bytes_ff  <= bytes_in;
      found_ff  <= found_in;
      best_ff   <= best_in;
      victim_ff <= victim_in;
      tmark_ff  <= tmark_in;
      tsize_ff  <= tsize_in;
   end

   assign res.cnt      = cnt_ff;
   assign res.bytes    = bytes_ff;
   assign res.victim   = victim_ff;
   assign res.tgt_mark = tmark_ff;
   assign res.tgt_size = tsize_ff;

endmodule

// ----- hw/rtl/layer_residency_manager.sv -----
// Top level of the layer residency manager: sequencer, cell ring, CSRs, result register.
//
//   channel  | direction | handshake                | contents
//   req_     | in        | tvalid/tready            | tuser func, tdata index and bytes
//   rsp_     | out       | tvalid/tready            | status, evictions, residents, bytes, position
//   csr_     | in/out    | psel/penable, pready = 1 | layer_count @0x0, resident_limit @0x4
//
// One transaction at a time. Each pass rotates the ring once, one cell per cycle past the
// tally unit; each layer evicted adds another pass.
// Synchronous reset clears all table entries, marks and the position; no clearing pass.
// A result waiting on rsp_tready holds the next finished transaction in its last step.
module layer_residency_manager #(
   parameter int MAX_LAYERS = lrm_pkg::DEF_MAX_LAYERS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [5:0] layer_index, [53:6] layer_bytes, [55:54] zero
   input  logic [lrm_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [1:0] func
   input  logic [lrm_pkg::FUNC_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] status, [7:1] evicted_count, [14:8] resident_count,
   // [68:15] resident_bytes, [75:69] position, [79:76] zero
   output logic [lrm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lrm_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [lrm_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [lrm_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                              csr_pready
);
   import lrm_pkg::*;

   localparam int IDX_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_LAYERS - 1);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_PREP   = 4'b0010,
      S_SCAN   = 4'b0100,
      S_DECIDE = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]      layer_count_ff, resident_limit_ff;
   logic [CNT_W-1:0]      pos_ff, pos_in;
   logic [CNT_W-1:0]      tgt_ff, tgt_in;
   logic [CNT_W-1:0]      evict_cnt_ff, evict_cnt_in;
   logic                  load_ff, load_in;
   logic                  status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   func_type              func_ff;
   logic [IDX_IN_W-1:0]   idx_ff;
   logic [SIZE_W-1:0]     bytes_ff;

   logic [CNT_W-1:0]      n_eff;
   logic                  idx_ok;
   logic [CNT_W:0]        pos_inc;
   logic                  need_evict;
   logic                  add_tgt;
   logic                  out_free;
   logic                  csr_wr;
   logic [CNT_W-1:0]      fin_cnt;
   logic [BYTES_W-1:0]    fin_bytes;
   logic [BYTES_W:0]      fin_sum;

   logic [SIZE_W-1:0]     cell_size [MAX_LAYERS];
   logic                  cell_mark [MAX_LAYERS];
   cell_ctl_type          cell_ctl;
   tally_ctl_type         tally_ctl;
   tally_res_type         tally_res;

   // ---- cell ring ----
   for (genvar g = 0; g < MAX_LAYERS; g++) begin : g_cell
      lrm_cell #(
         .CELL_IDX (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl),
         .next_size (cell_size[(g + 1) % MAX_LAYERS]),
         .next_mark (cell_mark[(g + 1) % MAX_LAYERS]),
         .size_q    (cell_size[g]),
         .mark_q    (cell_mark[g])
      );
   end

   lrm_tally #(
      .MAX_LAYERS (MAX_LAYERS)
   ) u_tally (
      .clock      (clock),
      .ctl        (tally_ctl),
      .entry_idx  (scan_idx_ff),
      .entry_size (cell_size[0]),
      .entry_mark (cell_mark[0]),
      .res        (tally_res)
   );

   // ---- derived values ----
   assign n_eff    = (int'(layer_count_ff) > MAX_LAYERS) ? CNT_W'(MAX_LAYERS) : layer_count_ff;
   assign idx_ok   = {1'b0, idx_ff} < n_eff;
   assign pos_inc  = {1'b0, pos_ff} + 1'b1;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign add_tgt    = load_ff && !tally_res.tgt_mark;
   assign need_evict = add_tgt && (tally_res.cnt != '0) && (tally_res.cnt >= resident_limit_ff);
   assign fin_sum    = {1'b0, tally_res.bytes} + (BYTES_W + 1)'(tally_res.tgt_size);

   always_comb begin
      if (add_tgt) begin
         fin_cnt   = tally_res.cnt + 1'b1;
         fin_bytes = (fin_sum > (BYTES_W + 1)'(BYTES_MAX)) ? BYTES_MAX : fin_sum[BYTES_W-1:0];
      end else begin
         fin_cnt   = tally_res.cnt;
         fin_bytes = tally_res.bytes;
      end
   end

   // ---- sequencer ----
   always_comb begin
      state_in     = state_ff;
      scan_idx_in  = scan_idx_ff;
      pos_in       = pos_ff;
      tgt_in       = tgt_ff;
      load_in      = load_ff;
      evict_cnt_in = evict_cnt_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      cell_ctl     = '0;
      tally_ctl.clear = 1'b0;
      tally_ctl.step  = 1'b0;
      tally_ctl.n     = n_eff;
      tally_ctl.pos   = pos_ff;
      tally_ctl.tgt   = tgt_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            status_in       = 1'b0;
            load_in         = 1'b0;
            evict_cnt_in    = '0;
            tally_ctl.clear = 1'b1;
            scan_idx_in     = '0;
            state_in        = S_SCAN;
            case (func_ff)
               FN_ADVANCE: begin
                  if (pos_ff < n_eff) begin
                     cell_ctl.wr_en = 1'b1;
                     cell_ctl.addr  = pos_ff;
                     cell_ctl.mark  = 1'b0;
                  end
                  if (pos_inc >= {1'b0, n_eff}) begin
                     pos_in = n_eff;
                  end else begin
                     pos_in  = pos_inc[CNT_W-1:0];
                     tgt_in  = pos_inc[CNT_W-1:0];
                     load_in = 1'b1;
                  end
               end
               default: begin
                  if (!idx_ok) begin
                     status_in = 1'b1;
                  end else if (func_ff inside {FN_REGISTER, FN_UNLOAD}) begin
                     cell_ctl.wr_en   = 1'b1;
                     cell_ctl.size_en = (func_ff == FN_REGISTER);
                     cell_ctl.addr    = {1'b0, idx_ff};
                     cell_ctl.mark    = 1'b0;
                     cell_ctl.size    = bytes_ff;
                  end else begin
                     load_in = 1'b1;
                     tgt_in  = {1'b0, idx_ff};
                  end
               end
            endcase
         end
         S_SCAN: begin
            tally_ctl.step = 1'b1;
            cell_ctl.shift = 1'b1;
            if (scan_idx_ff == LAST_IDX) begin
               scan_idx_in = '0;
               state_in    = S_DECIDE;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         S_DECIDE: begin
            if (need_evict) begin
               cell_ctl.wr_en  = 1'b1;
               cell_ctl.addr   = tally_res.victim;
               cell_ctl.mark   = 1'b0;
               evict_cnt_in    = evict_cnt_ff + 1'b1;
               tally_ctl.clear = 1'b1;
               scan_idx_in     = '0;
               state_in        = S_SCAN;
            end else if (out_free) begin
               if (add_tgt) begin
                  cell_ctl.wr_en = 1'b1;
                  cell_ctl.addr  = tgt_ff;
                  cell_ctl.mark  = 1'b1;
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{RSP_PAD_W{1'b0}}, pos_ff, fin_bytes, fin_cnt,
                               evict_cnt_ff, status_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         scan_idx_ff       <= '0;
         pos_ff            <= '0;
         load_ff           <= 1'b0;
         evict_cnt_ff      <= '0;
         rsp_valid_ff      <= 1'b0;
         layer_count_ff    <= LC_RESET;
         resident_limit_ff <= LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         scan_idx_ff  <= scan_idx_in;
         pos_ff       <= pos_in;
         load_ff      <= load_in;
         evict_cnt_ff <= evict_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr) begin
            case (csr_paddr[2])
               REG_LAYER_COUNT:    layer_count_ff    <= csr_pwdata[CNT_W-1:0];
               REG_RESIDENT_LIMIT: resident_limit_ff <= csr_pwdata[CNT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff      <= tgt_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      if (req_tvalid && req_tready) begin
         func_ff  <= func_type'(req_tuser);
         idx_ff   <= req_tdata[IDX_IN_W-1:0];
         bytes_ff <= req_tdata[IDX_IN_W +: SIZE_W];
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_LAYER_COUNT:    csr_prdata = CSR_DW'(layer_count_ff);
         REG_RESIDENT_LIMIT: csr_prdata = CSR_DW'(resident_limit_ff);
         default:            csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a transaction is in flight");

   a_ring_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_SCAN) |-> (scan_idx_ff == '0))
      else $error("ring not aligned outside a pass");

   a_evict_only_on_load: assert property (@(posedge clock) disable iff (reset)
      !load_ff |-> (evict_cnt_ff == '0))
      else $error("eviction counted without a load");

   a_result_from_decide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DECIDE))
      else $error("result produced outside the final step");
`endif

endmodule

// ----- tb/sv/layer_residency_manager_tb.sv -----
// Testbench for layer_residency_manager: predicts every response and checks it field by field.
`timescale 1ns / 100ps

module layer_residency_manager_tb;
   import lrm_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 200;
   localparam int MAX_PRINTS     = 30;

   typedef struct packed {
      logic              status;
      logic [CNT_W-1:0]   evicted;
      logic [CNT_W-1:0]   residents;
      logic [BYTES_W-1:0] bytes;
      logic [CNT_W-1:0]   position;
   } rsp_fields_type;

   class residency_tracker;
      logic [SIZE_W-1:0] layer_size [DEF_MAX_LAYERS];
      bit                resident [DEF_MAX_LAYERS];
      int                position;
      logic [59:0]       size_sum;
      int                layer_count;
      int                resident_limit;
      rsp_fields_type    expected_rsps [$];
      int                errors;
      int                responses;
      int                most_evicted;

      function new();
         foreach (layer_size[i]) begin
            layer_size[i] = '0;
            resident[i]   = 1'b0;
         end
         position       = 0;
         size_sum       = '0;
         layer_count    = LC_RESET;
         resident_limit = LIMIT_RESET;
         errors         = 0;
         responses      = 0;
         most_evicted   = 0;
      endfunction

      function void set_reg(logic sel, logic [CNT_W-1:0] value);
         if (sel == REG_LAYER_COUNT) begin
            layer_count = value;
         end else begin
            resident_limit = value;
         end
      endfunction

      function int active_layers();
         return (layer_count > DEF_MAX_LAYERS) ? DEF_MAX_LAYERS : layer_count;
      endfunction

      function int resident_total();
         int c;
         c = 0;
         for (int i = 0; i < active_layers(); i++)
            if (resident[i]) c++;
         return c;
      endfunction

      function logic [BYTES_W-1:0] resident_bytes_sum();
         logic [BYTES_W:0] s;
         s = '0;
         for (int i = 0; i < active_layers(); i++) begin
            if (resident[i]) begin
               s = s + layer_size[i];
               if (s > {1'b0, BYTES_MAX}) s = {1'b0, BYTES_MAX};
            end
         end
         return s[BYTES_W-1:0];
      endfunction

      // evict farthest-from-position residents (lowest index on ties) until below the limit or none remain
      function int bring_in(int idx);
         int n, evicted, count, victim, best, d;
         bit found;
         n = active_layers();
         evicted = 0;
         if (resident[idx]) return 0;
         count = resident_total();
         while (count > 0 && count >= resident_limit) begin
            found  = 1'b0;
            victim = 0;
            best   = 0;
            for (int i = 0; i < n; i++) begin
               if (resident[i]) begin
                  d = (position > i) ? position - i : i - position;
                  if (!found || d > best) begin
                     found  = 1'b1;
                     best   = d;
                     victim = i;
                  end
               end
            end
            if (!found) break;
            resident[victim] = 1'b0;
            count--;
            evicted++;
         end
         resident[idx] = 1'b1;
         return evicted;
      endfunction

      function rsp_fields_type predict_step(func_type f, int idx, logic [SIZE_W-1:0] b);
         rsp_fields_type r;
         int n, ev;
         logic [60:0] t;
         n  = active_layers();
         ev = 0;
         r.status = 1'b0;
         if (f != FN_ADVANCE && idx >= n) begin
            r.status = 1'b1;
         end else begin
            case (f)
               FN_REGISTER: begin
                  layer_size[idx] = b;
                  resident[idx]   = 1'b0;
                  t = size_sum + b;
                  size_sum = (t > {1'b0, {60{1'b1}}}) ? {60{1'b1}} : t[59:0];
               end
               FN_LOAD:   ev = bring_in(idx);
               FN_UNLOAD: resident[idx] = 1'b0;
               default: begin
                  if (position < n) resident[position] = 1'b0;
                  position++;
                  if (position >= n) position = n;
                  else ev = bring_in(position);
               end
            endcase
         end
         if (ev > most_evicted) most_evicted = ev;
         r.evicted   = CNT_W'(ev);
         r.residents = CNT_W'(resident_total());
         r.bytes     = resident_bytes_sum();
         r.position  = CNT_W'(position);
         return r;
      endfunction

      function void note_request(func_type f, logic [IDX_IN_W-1:0] idx, logic [SIZE_W-1:0] b);
         expected_rsps.push_back(predict_step(f, idx, b));
      endfunction

      function int pending();
         return expected_rsps.size();
      endfunction

      task report(string msg);
         errors++;
         if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
      endtask

      task compare_field(string name, longint unsigned got, longint unsigned want);
         if (got != want)
            report($sformatf("response %0d %s got 0x%0h want 0x%0h", responses, name, got, want));
      endtask

      task check_response(logic [RSP_DATA_W-1:0] d);
         rsp_fields_type want;
         responses++;
         if (expected_rsps.size() == 0) begin
            report($sformatf("response %0d arrived with nothing outstanding", responses));
         end else begin
            want = expected_rsps.pop_front();
            compare_field("status", d[0], want.status);
            compare_field("evicted_count", d[7:1], want.evicted);
            compare_field("resident_count", d[14:8], want.residents);
            compare_field("resident_bytes", d[68:15], want.bytes);
            compare_field("position", d[75:69], want.position);
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [FUNC_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]     csr_paddr = '0;
   logic [CSR_DW-1:0]     csr_pwdata = '0;
   logic [CSR_DW-1:0]     csr_prdata;
   logic                  csr_pready;

   residency_tracker tracker;
   bit               idle_on = 1'b1;
   int               quiet_cycles = 0;
   int               settings_used = 0;

   layer_residency_manager dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d idle cycles, %0d responses outstanding",
                  quiet_cycles, tracker.pending());
         $display("** layer_residency_manager: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // response side: random stall before each transaction while idle_on is set
   initial begin
      int stall;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, 9) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         tracker.check_response(rsp_tdata);
      end
   end

   task write_reg(logic sel, logic [CNT_W-1:0] value);
      logic [CSR_DW-1:0] upper;
      upper = $urandom_range(0, 1) ? $urandom : '0;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= {upper[CSR_DW-1:CNT_W], value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.set_reg(sel, value);
   endtask

   task issue_request(func_type f, logic [IDX_IN_W-1:0] idx, logic [SIZE_W-1:0] b);
      int gap;
      gap = idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {2'b00, b, idx};
      do @(posedge clock); while (!req_tready);
      tracker.note_request(f, idx, b);
   endtask

   task issue_random_request();
      int r, n;
      logic [IDX_IN_W-1:0] idx;
      logic [63:0] raw;
      func_type f;
      n = tracker.active_layers();
      r = $urandom_range(0, 99);
      if (r < 20) f = FN_REGISTER;
      else if (r < 60) f = FN_LOAD;
      else if (r < 80) f = FN_UNLOAD;
      else f = FN_ADVANCE;
      if (n > 0 && $urandom_range(0, 9) != 0) idx = IDX_IN_W'($urandom_range(0, n - 1));
      else idx = IDX_IN_W'($urandom_range(0, 63));
      r = $urandom_range(0, 9);
      if (r == 0) raw = '0;
      else if (r == 1) raw = '1;
      else raw = {$urandom, $urandom};
      issue_request(f, idx, raw[SIZE_W-1:0]);
   endtask

   // drop valid and let every outstanding response return
   task settle();
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task run_phase(int lc, int lim, int items);
      idle_on = ($urandom_range(0, 3) != 0);
      write_reg(REG_LAYER_COUNT, CNT_W'(lc));
      write_reg(REG_RESIDENT_LIMIT, CNT_W'(lim));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      settings_used++;
      repeat (items) issue_random_request();
      settle();
   endtask

   initial begin
      int lc, lim;
      tracker = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: 32 layers, limit 4
      settings_used = 1;
      issue_request(FN_REGISTER, 6'd0, {SIZE_W{1'b1}});
      issue_request(FN_REGISTER, 6'd1, '0);
      issue_request(FN_REGISTER, 6'd2, 48'h0123_4567_89ab);
      issue_request(FN_REGISTER, 6'd3, 48'd1);
      issue_request(FN_REGISTER, 6'd31, 48'hfedc_ba98_7654);
      issue_request(FN_REGISTER, 6'd32, 48'h5555_5555_5555);
      issue_request(FN_REGISTER, 6'd63, 48'haaaa_aaaa_aaaa);
      issue_request(FN_LOAD, 6'd0, '0);
      issue_request(FN_LOAD, 6'd0, '0);
      issue_request(FN_LOAD, 6'd1, '0);
      issue_request(FN_LOAD, 6'd2, '0);
      issue_request(FN_LOAD, 6'd3, '0);
      issue_request(FN_LOAD, 6'd31, '0);
      issue_request(FN_ADVANCE, 6'd0, '0);
      issue_request(FN_UNLOAD, 6'd2, '0);
      issue_request(FN_UNLOAD, 6'd40, '0);
      issue_request(FN_LOAD, 6'd50, '0);
      issue_request(FN_ADVANCE, 6'd63, '1);
      issue_request(FN_REGISTER, 6'd1, 48'h8000_0000_0000);
      issue_request(FN_LOAD, 6'd31, '0);
      issue_request(FN_LOAD, 6'd1, '0);
      issue_request(FN_ADVANCE, 6'd0, '0);
      settle();

      run_phase(64, 64, 90);
      run_phase(64, 2, 60);
      run_phase(20, 0, 60);
      run_phase(127, 8, 70);
      run_phase(5, 3, 50);
      run_phase(0, 4, 20);
      run_phase(1, 1, 30);
      run_phase(64, 127, 70);
      repeat (4) begin
         lc  = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 127) : $urandom_range(1, 64);
         lim = $urandom_range(0, 66);
         run_phase(lc, lim, 50);
      end

      idle_on = 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d responses across %0d register settings, up to %0d evictions per transaction.",
               tracker.responses, settings_used, tracker.most_evicted);
      $display("Counts from zero to above the table size, limits from zero to 127; %0d mismatches.",
               tracker.errors);
      if (tracker.errors == 0) begin
         $display("** layer_residency_manager: PASSED **");
      end else begin
         $display("** layer_residency_manager: FAILED **");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/lrm_pkg.sv
hw/rtl/lrm_cell.sv
hw/rtl/lrm_tally.sv
hw/rtl/layer_residency_manager.sv
tb/sv/layer_residency_manager_tb.sv
